// File: rtl/bta_pkg.sv
package bta_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int ADDR_W         = 15;
    localparam int REQ_W          = 16;
    localparam int UNIT_SHIFT     = 3;
    localparam int NEED_W         = 14;
    localparam int OVERHEAD       = 2;
    localparam int GRANT_W        = ADDR_W - UNIT_SHIFT;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  req_bytes;
        logic [ADDR_W-1:0] block_addr;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] granted_addr;
    } out_word_t;

    typedef enum logic [3:0] {
        A_CLR,
        A_POS,
        A_POS_TAKE_M1,
        A_POS_TAKE,
        A_POS_SIZE_M1,
        A_START,
        A_START_SIZE_M1,
        A_START_SIZE,
        A_START_M1,
        A_FIRST,
        A_LAST
    } addr_sel_t;

    typedef enum logic [2:0] {
        D_ZERO,
        D_CLR,
        D_TAKE,
        D_REST,
        D_MERGED
    } data_sel_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_EVAL,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_F_CHK,
        S_F_HDR,
        S_F_FRD,
        S_F_FTR,
        S_F_PRV,
        S_F_NRD,
        S_F_NXT,
        S_F_Z0,
        S_F_Z1,
        S_F_Z2,
        S_F_Z3,
        S_F_WF,
        S_F_WL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      load_in;
        logic      clr_inc;
        logic      rd_en;
        logic      wr_en;
        addr_sel_t addr_sel;
        data_sel_t data_sel;
        logic      pos_adv;
        logic      cap_tag;
        logic      init_span;
        logic      merge_prev;
        logic      merge_next;
        logic      set_fail;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic in_free;
        logic clr_last;
        logic pos_end;
        logic walk_bad;
        logic walk_fit;
        logic split;
        logic addr_bad;
        logic hdr_bad;
        logic ftr_bad;
        logic has_prev;
        logic prv_merge;
        logic has_next;
        logic nxt_merge;
        logic mp;
        logic mn;
        logic out_busy;
    } stat_t;

endpackage

// File: rtl/bta_ctrl.sv
module bta_ctrl import bta_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (stat.clr_last) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) state_next = stat.in_free ? S_F_CHK : S_A_RD;
            end
            S_A_RD:   state_next = stat.pos_end ? S_DONE : S_A_EVAL;
            S_A_EVAL: begin
                if (stat.walk_bad)      state_next = S_DONE;
                else if (stat.walk_fit) state_next = S_A_W0;
                else                    state_next = S_A_RD;
            end
            S_A_W0:   state_next = S_A_W1;
            S_A_W1:   state_next = stat.split ? S_A_W2 : S_DONE;
            S_A_W2:   state_next = S_A_W3;
            S_A_W3:   state_next = S_DONE;
            S_F_CHK:  state_next = stat.addr_bad ? S_DONE : S_F_HDR;
            S_F_HDR:  state_next = stat.hdr_bad ? S_DONE : S_F_FRD;
            S_F_FRD:  state_next = S_F_FTR;
            S_F_FTR: begin
                if (stat.ftr_bad)       state_next = S_DONE;
                else if (stat.has_prev) state_next = S_F_PRV;
                else                    state_next = S_F_NRD;
            end
            S_F_PRV:  state_next = S_F_NRD;
            S_F_NRD:  state_next = stat.has_next ? S_F_NXT : S_F_Z0;
            S_F_NXT:  state_next = S_F_Z0;
            S_F_Z0:   state_next = S_F_Z1;
            S_F_Z1:   state_next = S_F_Z2;
            S_F_Z2:   state_next = S_F_Z3;
            S_F_Z3:   state_next = S_F_WF;
            S_F_WF:   state_next = S_F_WL;
            S_F_WL:   state_next = S_DONE;
            S_DONE:   if (!stat.out_busy) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = A_POS;
        cmd.data_sel = D_ZERO;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.wr_en    = 1'b1;
                cmd.clr_inc  = 1'b1;
                cmd.addr_sel = A_CLR;
                cmd.data_sel = D_CLR;
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_A_RD: begin
                cmd.rd_en    = !stat.pos_end;
                cmd.set_fail = stat.pos_end;
            end
            S_A_EVAL: begin
                cmd.cap_tag  = 1'b1;
                cmd.set_fail = stat.walk_bad;
                cmd.pos_adv  = !stat.walk_bad && !stat.walk_fit;
            end
            S_A_W0: begin
                cmd.wr_en    = 1'b1;
                cmd.data_sel = D_TAKE;
            end
            S_A_W1: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_POS_TAKE_M1;
                cmd.data_sel = D_TAKE;
            end
            S_A_W2: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_POS_TAKE;
                cmd.data_sel = D_REST;
            end
            S_A_W3: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_POS_SIZE_M1;
                cmd.data_sel = D_REST;
            end
            S_F_CHK: begin
                cmd.rd_en    = !stat.addr_bad;
                cmd.addr_sel = A_START;
            end
            S_F_HDR: cmd.cap_tag = 1'b1;
            S_F_FRD: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_START_SIZE_M1;
            end
            S_F_FTR: begin
                cmd.init_span = 1'b1;
                cmd.rd_en     = !stat.ftr_bad && stat.has_prev;
                cmd.addr_sel  = A_START_M1;
            end
            S_F_PRV: cmd.merge_prev = stat.prv_merge;
            S_F_NRD: begin
                cmd.rd_en    = stat.has_next;
                cmd.addr_sel = A_START_SIZE;
            end
            S_F_NXT: cmd.merge_next = stat.nxt_merge;
            S_F_Z0: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_START;
            end
            S_F_Z1: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_START_SIZE_M1;
            end
            S_F_Z2: begin
                cmd.wr_en    = stat.mp;
                cmd.addr_sel = A_START_M1;
            end
            S_F_Z3: begin
                cmd.wr_en    = stat.mn;
                cmd.addr_sel = A_START_SIZE;
            end
            S_F_WF: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_FIRST;
                cmd.data_sel = D_MERGED;
            end
            S_F_WL: begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = A_LAST;
                cmd.data_sel = D_MERGED;
            end
            S_DONE: cmd.out_load = !stat.out_busy;
            default: cmd.load_in = 1'b0;
        endcase
    end

endmodule

// File: rtl/bta_dp.sv
module bta_dp import bta_pkg::*; #(
    parameter int HEAP_UNITS = HEAP_UNITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  cmd_t      cmd,
    output stat_t     stat
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int SW = $clog2(HEAP_UNITS + 1);
    localparam int TW = SW + 1;
    localparam int CW = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int GW = (SW > GRANT_W) ? SW : GRANT_W;
    localparam logic [SW-1:0] HU = SW'(HEAP_UNITS);

    logic [TW-1:0] tag_mem [HEAP_UNITS];

    logic [TW-1:0]     rd_data_reg;
    logic [TW-1:0]     t_reg;
    logic [AW-1:0]     clr_reg;
    logic [SW-1:0]     pos_reg;
    logic [SW-1:0]     first_reg;
    logic [SW-1:0]     last_reg;
    logic [NEED_W-1:0] need_reg;
    logic [ADDR_W-1:0] blk_reg;
    logic              op_reg;
    logic              fail_reg;
    logic              mp_reg;
    logic              mn_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic [SW-1:0]     rd_size, t_size, take, rest, start, merged;
    logic              rd_alloc;
    logic [CW-1:0]     diff;
    logic [GW-1:0]     start_g, grant_g;
    logic [SW-1:0]     addr_w;
    logic [TW-1:0]     wd;
    logic [REQ_W:0]    req_round;

    assign rd_size  = rd_data_reg[TW-1:1];
    assign rd_alloc = rd_data_reg[0];
    assign t_size   = t_reg[TW-1:1];

    // take the whole block when the remainder could not hold its own tags
    assign diff   = CW'(t_size) - CW'(need_reg);
    assign take   = (diff >= CW'(OVERHEAD)) ? SW'(need_reg) : t_size;
    assign rest   = t_size - take;
    assign start_g = GW'(blk_reg[ADDR_W-1:UNIT_SHIFT]) - GW'(1);
    assign start  = start_g[SW-1:0];
    assign merged = last_reg - first_reg + SW'(1);
    assign grant_g = GW'(pos_reg) + GW'(1);
    assign req_round = (REQ_W+1)'(s_data.req_bytes) + (REQ_W+1)'(7);

    always_comb begin
        stat.in_free   = (s_data.op == OP_FREE);
        stat.clr_last  = (clr_reg == AW'(HEAP_UNITS - 1));
        stat.pos_end   = (pos_reg >= HU);
        stat.walk_bad  = (rd_size == '0) || (rd_size > HU - pos_reg);
        stat.walk_fit  = !rd_alloc && (CW'(rd_size) > CW'(need_reg));
        stat.split     = (take != t_size);
        stat.addr_bad  = (blk_reg[UNIT_SHIFT-1:0] != '0)
                      || (blk_reg[ADDR_W-1:UNIT_SHIFT] == '0)
                      || (start_g >= GW'(HEAP_UNITS));
        stat.hdr_bad   = !rd_alloc || (rd_size < SW'(2)) || (rd_size > HU - start);
        stat.ftr_bad   = (rd_data_reg != t_reg);
        stat.has_prev  = (start != '0);
        stat.prv_merge = (rd_data_reg != '0) && !rd_alloc && (rd_size <= start);
        stat.has_next  = (last_reg < HU - SW'(1));
        stat.nxt_merge = (rd_data_reg != '0) && !rd_alloc
                      && (rd_size <= HU - SW'(1) - last_reg);
        stat.mp        = mp_reg;
        stat.mn        = mn_reg;
        stat.out_busy  = m_valid_reg && !m_ready;
    end

    always_comb begin
        case (cmd.addr_sel)
            A_CLR:           addr_w = SW'(clr_reg);
            A_POS:           addr_w = pos_reg;
            A_POS_TAKE_M1:   addr_w = pos_reg + take - SW'(1);
            A_POS_TAKE:      addr_w = pos_reg + take;
            A_POS_SIZE_M1:   addr_w = pos_reg + t_size - SW'(1);
            A_START:         addr_w = start;
            A_START_SIZE_M1: addr_w = start + t_size - SW'(1);
            A_START_SIZE:    addr_w = start + t_size;
            A_START_M1:      addr_w = start - SW'(1);
            A_FIRST:         addr_w = first_reg;
            A_LAST:          addr_w = last_reg;
            default:         addr_w = pos_reg;
        endcase
    end

    always_comb begin
        case (cmd.data_sel)
            D_CLR:    wd = ((clr_reg == '0) || stat.clr_last) ? {HU, 1'b0} : '0;
            D_TAKE:   wd = {take, 1'b1};
            D_REST:   wd = {rest, 1'b0};
            D_MERGED: wd = {merged, 1'b0};
            default:  wd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) tag_mem[addr_w[AW-1:0]] <= wd;
        if (cmd.rd_en) rd_data_reg <= tag_mem[addr_w[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_inc) clr_reg <= clr_reg + AW'(1);
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_data.op;
            need_reg <= NEED_W'(req_round >> UNIT_SHIFT) + NEED_W'(OVERHEAD);
            blk_reg  <= s_data.block_addr;
            pos_reg  <= '0;
            fail_reg <= 1'b0;
            mp_reg   <= 1'b0;
            mn_reg   <= 1'b0;
        end
        if (cmd.pos_adv)  pos_reg  <= pos_reg + rd_size;
        if (cmd.cap_tag)  t_reg    <= rd_data_reg;
        if (cmd.set_fail) fail_reg <= 1'b1;
        if (cmd.init_span) begin
            first_reg <= start;
            last_reg  <= start + t_size - SW'(1);
        end
        if (cmd.merge_prev) begin
            first_reg <= start - rd_size;
            mp_reg    <= 1'b1;
        end
        if (cmd.merge_next) begin
            last_reg <= last_reg + rd_size;
            mn_reg   <= 1'b1;
        end
        if (cmd.out_load) begin
            m_data_reg.status <= fail_reg;
            m_data_reg.granted_addr <= (op_reg == OP_ALLOC && !fail_reg)
                ? {grant_g[GRANT_W-1:0], {UNIT_SHIFT{1'b0}}} : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/boundary_tag_first_fit_allocator.sv
// Allocate, word to word: each block tag walked is read and then evaluated; a grant writes
// the granted block's tags (and the remainder's when split); a walk off the heap end fails.
// Free, word to word: the time taken depends on early rejection and neighbor reads.
// One word in flight at a time; the walk's tag memory reads set the allocate time.
// Reset: synchronous, active low; a clearing pass then writes every tag unit,
// with s_ready low until it finishes.
module boundary_tag_first_fit_allocator import bta_pkg::*; #(
    parameter int HEAP_UNITS = HEAP_UNITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // Controller sequences tag memory reads/writes; datapath holds the
    // tag memory, walk pointer, span registers and the output word register.
    cmd_t  cmd;
    stat_t stat;

    bta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bta_dp #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
